[rtl/bidx_pkg.sv]
// shared constants, types and helpers of the broadcast index generator
package bidx_pkg;

  localparam int MAX_RANK_DEF    = 4;
  localparam int DIM_WIDTH_DEF   = 16;
  localparam int INDEX_WIDTH_DEF = 32;
  localparam int DIM_W_MAX       = 16;
  localparam int STEP_BITS       = 2;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;

  localparam logic [2:0] REG_OUTPUT_SHAPE = 3'd0;
  localparam logic [2:0] REG_A_SHAPE      = 3'd1;
  localparam logic [2:0] REG_B_SHAPE      = 3'd2;
  localparam logic [2:0] REG_OUTPUT_RANK  = 3'd3;
  localparam logic [2:0] REG_A_RANK       = 3'd4;
  localparam logic [2:0] REG_B_RANK       = 3'd5;

  localparam logic [CFG_DATA_W-1:0] SHAPE_RESET = 64'h0001_0001_0001_0001;
  localparam logic [2:0]            RANK_RESET  = 3'd1;

  typedef struct packed {
    logic [2:0] out_rank;
    logic [2:0] a_rank;
    logic [2:0] b_rank;
  } rank_cfg_t;

  function automatic logic [2:0] rank_clamp(logic [2:0] r, logic [2:0] max_rank);
    return (r > max_rank) ? max_rank : r;
  endfunction

  function automatic logic [DIM_W_MAX-1:0] dim_fix(logic [DIM_W_MAX-1:0] d);
    return (d == '0) ? DIM_W_MAX'(1) : d;
  endfunction

endpackage

[rtl/bidx_divider.sv]
// pipelined restoring divider for one dimension, a few quotient bits per stage
module bidx_divider import bidx_pkg::*; #(
  parameter int IW  = INDEX_WIDTH_DEF,
  parameter int DW  = DIM_WIDTH_DEF,
  parameter int BPS = STEP_BITS,
  parameter int SBW = IW
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           vld_i,
  input  logic [IW-1:0]  dividend_i,
  input  logic [DW-1:0]  divisor_i,
  input  logic [SBW-1:0] sb_i,
  output logic           vld_o,
  output logic [IW-1:0]  quot_o,
  output logic [DW-1:0]  rem_o,
  output logic [SBW-1:0] sb_o
);

  localparam int NS = (IW + BPS - 1) / BPS;

  logic           vld_q  [NS];
  logic [IW-1:0]  work_q [NS];
  logic [DW-1:0]  rem_q  [NS];
  logic [SBW-1:0] sb_q   [NS];

  logic           vld_in  [NS];
  logic [IW-1:0]  work_in [NS];
  logic [DW-1:0]  rem_in  [NS];
  logic [SBW-1:0] sb_in   [NS];
  logic [IW-1:0]  work_d  [NS];
  logic [DW-1:0]  rem_d   [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign vld_in[s]  = vld_i;
      assign work_in[s] = dividend_i;
      assign rem_in[s]  = '0;
      assign sb_in[s]   = sb_i;
    end else begin : g_next
      assign vld_in[s]  = vld_q[s-1];
      assign work_in[s] = work_q[s-1];
      assign rem_in[s]  = rem_q[s-1];
      assign sb_in[s]   = sb_q[s-1];
    end

    always_comb begin
      logic [IW-1:0] w;
      logic [DW-1:0] r;
      logic [DW:0]   t;
      logic          qb;
      w  = work_in[s];
      r  = rem_in[s];
      t  = '0;
      qb = 1'b0;
      for (int j = 0; j < BPS; j++) begin
        if (s * BPS + j < IW) begin
          t = {r, w[IW-1]};
          if (t >= {1'b0, divisor_i}) begin
            t  = t - {1'b0, divisor_i};
            qb = 1'b1;
          end else begin
            qb = 1'b0;
          end
          w = {w[IW-2:0], qb};
          r = t[DW-1:0];
        end
      end
      work_d[s] = w;
      rem_d[s]  = r;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        work_q[s] <= work_d[s];
        rem_q[s]  <= rem_d[s];
        sb_q[s]   <= sb_in[s];
      end
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign quot_o = work_q[NS-1];
  assign rem_o  = rem_q[NS-1];
  assign sb_o   = sb_q[NS-1];

endmodule

[rtl/bidx_stride.sv]
// registered broadcast stride chains for both operands
module bidx_stride import bidx_pkg::*; #(
  parameter int MR = MAX_RANK_DEF,
  parameter int DW = DIM_WIDTH_DEF,
  parameter int IW = INDEX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic [CFG_DATA_W-1:0] out_shape_i,
  input  logic [CFG_DATA_W-1:0] a_shape_i,
  input  logic [CFG_DATA_W-1:0] b_shape_i,
  input  rank_cfg_t             rank_i,
  output logic [MR*IW-1:0]      bstr_a_o,
  output logic [MR*IW-1:0]      bstr_b_o
);

  logic [IW-1:0] run_a_q [MR];
  logic [IW-1:0] run_b_q [MR];
  logic [IW-1:0] str_a_q [MR];
  logic [IW-1:0] str_b_q [MR];

  for (genvar k = 0; k < MR; k++) begin : g_dim
    logic [DW-1:0] d_out, d_a, d_b;
    logic          use_a, use_b;

    assign d_out = DW'(dim_fix(DIM_W_MAX'(out_shape_i[k*DW +: DW])));
    assign d_a   = DW'(dim_fix(DIM_W_MAX'(a_shape_i[k*DW +: DW])));
    assign d_b   = DW'(dim_fix(DIM_W_MAX'(b_shape_i[k*DW +: DW])));
    assign use_a = (k < int'(rank_i.a_rank)) && (k < int'(rank_i.out_rank));
    assign use_b = (k < int'(rank_i.b_rank)) && (k < int'(rank_i.out_rank));

    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        run_a_q[k] <= IW'(1);
        run_b_q[k] <= IW'(1);
      end
    end

    if (k + 1 < MR) begin : g_chain
      always_ff @(posedge clk_i) begin
        run_a_q[k+1] <= use_a ? IW'(run_a_q[k] * IW'(d_a)) : run_a_q[k];
        run_b_q[k+1] <= use_b ? IW'(run_b_q[k] * IW'(d_b)) : run_b_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      str_a_q[k] <= (use_a && d_a == d_out) ? run_a_q[k] : '0;
      str_b_q[k] <= (use_b && d_b == d_out) ? run_b_q[k] : '0;
    end

    assign bstr_a_o[k*IW +: IW] = str_a_q[k];
    assign bstr_b_o[k*IW +: IW] = str_b_q[k];
  end

endmodule

[rtl/bidx_mac.sv]
// coordinate times stride products and the registered sum tree
module bidx_mac import bidx_pkg::*; #(
  parameter int MR = MAX_RANK_DEF,
  parameter int IW = INDEX_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             vld_i,
  input  logic [MR*IW-1:0] coord_i,
  input  logic [MR*IW-1:0] bstr_a_i,
  input  logic [MR*IW-1:0] bstr_b_i,
  output logic             vld_o,
  output logic [IW-1:0]    idx_a_o,
  output logic [IW-1:0]    idx_b_o
);

  logic          vld_q [3];
  logic [IW-1:0] pa_q [4];
  logic [IW-1:0] pb_q [4];
  logic [IW-1:0] sa01_q, sa23_q, sb01_q, sb23_q;
  logic [IW-1:0] ia_q, ib_q;

  for (genvar k = 0; k < 4; k++) begin : g_prod
    if (k < MR) begin : g_used
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          pa_q[k] <= IW'(coord_i[k*IW +: IW] * bstr_a_i[k*IW +: IW]);
          pb_q[k] <= IW'(coord_i[k*IW +: IW] * bstr_b_i[k*IW +: IW]);
        end
      end
    end else begin : g_pad
      assign pa_q[k] = '0;
      assign pb_q[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
      vld_q[1] <= 1'b0;
      vld_q[2] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= vld_i;
      vld_q[1] <= vld_q[0];
      vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sa01_q <= pa_q[0] + pa_q[1];
      sa23_q <= pa_q[2] + pa_q[3];
      sb01_q <= pb_q[0] + pb_q[1];
      sb23_q <= pb_q[2] + pb_q[3];
      ia_q   <= sa01_q + sa23_q;
      ib_q   <= sb01_q + sb23_q;
    end
  end

  assign vld_o   = vld_q[2];
  assign idx_a_o = ia_q;
  assign idx_b_o = ib_q;

endmodule

[rtl/broadcast_index_generator.sv]
// top level of the broadcast index generator: registers, divider chain, sum
//
//   channel  direction  handshake                  payload
//   input    in         in_valid_i / in_stall_o    output_index_i
//   output   out        out_valid_o / out_stall_i  index_a_o, index_b_o
//   config   in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// one transaction per cycle while the output is not stalled; the path runs through
// the per-dimension divider stages and then the sum tree
// reset clears all valid bits and loads unit shapes and rank one
// an output stall with out_valid_o high freezes the whole pipeline; in_stall_o rises with it
module broadcast_index_generator import bidx_pkg::*; #(
  parameter int MAX_RANK    = MAX_RANK_DEF,
  parameter int DIM_WIDTH   = DIM_WIDTH_DEF,
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [INDEX_WIDTH-1:0] output_index_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [INDEX_WIDTH-1:0] index_a_o,
  output logic [INDEX_WIDTH-1:0] index_b_o
);

  localparam int MR  = MAX_RANK;
  localparam int DW  = DIM_WIDTH;
  localparam int IW  = INDEX_WIDTH;
  localparam int SBW = MR * IW;

  logic [CFG_DATA_W-1:0] out_shape_q, a_shape_q, b_shape_q;
  logic [2:0]            out_rank_q, a_rank_q, b_rank_q;
  rank_cfg_t             rank;
  logic                  adv;
  logic [2:0]            reg_idx;

  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_shape_q <= SHAPE_RESET;
      a_shape_q   <= SHAPE_RESET;
      b_shape_q   <= SHAPE_RESET;
      out_rank_q  <= RANK_RESET;
      a_rank_q    <= RANK_RESET;
      b_rank_q    <= RANK_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_OUTPUT_SHAPE: out_shape_q <= pwdata;
        REG_A_SHAPE:      a_shape_q   <= pwdata;
        REG_B_SHAPE:      b_shape_q   <= pwdata;
        REG_OUTPUT_RANK:  out_rank_q  <= pwdata[2:0];
        REG_A_RANK:       a_rank_q    <= pwdata[2:0];
        REG_B_RANK:       b_rank_q    <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OUTPUT_SHAPE: prdata = out_shape_q;
      REG_A_SHAPE:      prdata = a_shape_q;
      REG_B_SHAPE:      prdata = b_shape_q;
      REG_OUTPUT_RANK:  prdata = CFG_DATA_W'(out_rank_q);
      REG_A_RANK:       prdata = CFG_DATA_W'(a_rank_q);
      REG_B_RANK:       prdata = CFG_DATA_W'(b_rank_q);
      default:          prdata = '0;
    endcase
  end

  assign rank.out_rank = rank_clamp(out_rank_q, 3'(MR));
  assign rank.a_rank   = rank_clamp(a_rank_q, 3'(MR));
  assign rank.b_rank   = rank_clamp(b_rank_q, 3'(MR));

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  logic [MR*IW-1:0] bstr_a, bstr_b;

  bidx_stride #(.MR(MR), .DW(DW), .IW(IW)) u_stride (
    .clk_i      (clk_i),
    .out_shape_i(out_shape_q),
    .a_shape_i  (a_shape_q),
    .b_shape_i  (b_shape_q),
    .rank_i     (rank),
    .bstr_a_o   (bstr_a),
    .bstr_b_o   (bstr_b)
  );

  logic           vld   [MR];
  logic [IW-1:0]  quot  [MR];
  logic [DW-1:0]  remd  [MR];
  logic [SBW-1:0] sb_out[MR];
  logic [SBW-1:0] sb_nx [MR];

  for (genvar k = 0; k < MR; k++) begin : g_dim
    logic           vld_in;
    logic [IW-1:0]  div_in;
    logic [SBW-1:0] sb_in;
    logic [DW-1:0]  divisor;
    logic           outer;

    if (k == 0) begin : g_first
      assign vld_in = in_valid_i;
      assign div_in = output_index_i;
      assign sb_in  = '0;
    end else begin : g_next
      assign vld_in = vld[k-1];
      assign div_in = quot[k-1];
      assign sb_in  = sb_nx[k-1];
    end

    assign divisor = (k + 1 < int'(rank.out_rank))
                   ? DW'(dim_fix(DIM_W_MAX'(out_shape_q[k*DW +: DW])))
                   : DW'(1);
    assign outer   = (k + 1 == int'(rank.out_rank));

    bidx_divider #(.IW(IW), .DW(DW), .BPS(STEP_BITS), .SBW(SBW)) u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .vld_i     (vld_in),
      .dividend_i(div_in),
      .divisor_i (divisor),
      .sb_i      (sb_in),
      .vld_o     (vld[k]),
      .quot_o    (quot[k]),
      .rem_o     (remd[k]),
      .sb_o      (sb_out[k])
    );

    always_comb begin
      sb_nx[k] = sb_out[k];
      sb_nx[k][k*IW +: IW] = outer ? quot[k] : IW'(remd[k]);
    end
  end

  bidx_mac #(.MR(MR), .IW(IW)) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .vld_i     (vld[MR-1]),
    .coord_i   (sb_nx[MR-1]),
    .bstr_a_i  (bstr_a),
    .bstr_b_i  (bstr_b),
    .vld_o     (out_valid_o),
    .idx_a_o   (index_a_o),
    .idx_b_o   (index_b_o)
  );

endmodule

[rtl/bidx_checker.sv]
// port-level checks of the broadcast index generator and their binding
module bidx_checker import bidx_pkg::*; #(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [INDEX_WIDTH-1:0] index_a_o,
  input logic [INDEX_WIDTH-1:0] index_b_o
);

  // a held result transaction stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(index_a_o) && $stable(index_b_o)))
    else $error("held result changed");

  // a blocked output freezes the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while output blocked");

  // no empty output slot ever stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind broadcast_index_generator bidx_checker #(.INDEX_WIDTH(INDEX_WIDTH)) u_bidx_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .index_a_o  (index_a_o),
  .index_b_o  (index_b_o)
);

[test/tb.sv]
// testbench for the broadcast index generator: shaped configs, directed and random indices
`timescale 1ns / 100ps
module tb import bidx_pkg::*;;
  localparam int LIMIT = 1500000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [31:0] output_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [31:0] index_a_o, index_b_o;

  broadcast_index_generator u_top (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // local copy of the register file
  logic [63:0] shp_out, shp_a, shp_b;
  logic [2:0] rk_out, rk_a, rk_b;

  logic [31:0] pending_idx[$];
  logic [63:0] expected_pairs[$];
  int errors = 0;
  int n_checked = 0;
  int n_configs = 0;
  longint cycles = 0;

  function automatic longint unsigned dim_at(logic [63:0] s, int k);
    logic [15:0] v;
    v = s[k*16 +: 16];
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int clamp_rank(logic [2:0] r);
    return (r > 4) ? 4 : r;
  endfunction

  function automatic logic [63:0] broadcast_indices(logic [31:0] idx);
    longint unsigned ostr[4], sa[4], sb[4];
    longint unsigned run, runa, runb, rem, c, ia, ib;
    int orank, ar, br;
    orank = clamp_rank(rk_out);
    ar = clamp_rank(rk_a);
    br = clamp_rank(rk_b);
    run = 1; runa = 1; runb = 1;
    for (int k = 0; k < 4; k++) begin
      ostr[k] = run;
      if (k < orank) run *= dim_at(shp_out, k);
      sa[k] = 0;
      sb[k] = 0;
      if (k < ar && k < orank) begin
        if (dim_at(shp_a, k) == dim_at(shp_out, k)) sa[k] = runa;
        runa *= dim_at(shp_a, k);
      end
      if (k < br && k < orank) begin
        if (dim_at(shp_b, k) == dim_at(shp_out, k)) sb[k] = runb;
        runb *= dim_at(shp_b, k);
      end
    end
    rem = idx;
    ia = 0;
    ib = 0;
    for (int k = orank - 1; k >= 0; k--) begin
      c = rem / ostr[k];
      rem = rem % ostr[k];
      ia += c * sa[k];
      ib += c * sb[k];
    end
    return {ia[31:0], ib[31:0]};
  endfunction

  function automatic longint unsigned total_size();
    longint unsigned t;
    t = 1;
    for (int k = 0; k < clamp_rank(rk_out); k++) t *= dim_at(shp_out, k);
    return t;
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (in_valid_i && !in_stall_o) begin
      expected_pairs.push_back(broadcast_indices(output_index_i));
      void'(pending_idx.pop_front());
    end
    if (in_valid_i && in_stall_o) begin
    end else if (in_gap > 0 || pending_idx.size() == 0) begin
      in_valid_i <= 1'b0;
      if (in_gap > 0) in_gap <= in_gap - 1;
    end else begin
      in_valid_i <= 1'b1;
      output_index_i <= pending_idx[0];
      in_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk_i) begin
    logic [63:0] exp_pair;
    int w;
    if (out_valid_o && !out_stall_i) begin
      if (expected_pairs.size() == 0) begin
        $display("%0t unexpected transaction a=%h b=%h", $time, index_a_o, index_b_o);
        errors++;
      end else begin
        exp_pair = expected_pairs.pop_front();
        n_checked <= n_checked + 1;
        if (exp_pair[63:32] !== index_a_o) begin
          $display("%0t index_a expected %h actual %h", $time, exp_pair[63:32], index_a_o);
          errors++;
        end
        if (exp_pair[31:0] !== index_b_o) begin
          $display("%0t index_b expected %h actual %h", $time, exp_pair[31:0], index_b_o);
          errors++;
        end
      end
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      out_gap <= w;
      out_stall_i <= (w != 0);
    end else if (out_valid_o && out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall_i <= (out_gap > 1);
    end
  end

  task automatic cfg_write(logic [2:0] reg_id, logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= CFG_ADDR_W'(reg_id) << 3; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (reg_id)
      REG_OUTPUT_SHAPE: shp_out = value;
      REG_A_SHAPE:      shp_a = value;
      REG_B_SHAPE:      shp_b = value;
      REG_OUTPUT_RANK:  rk_out = value[2:0];
      REG_A_RANK:       rk_a = value[2:0];
      default:          rk_b = value[2:0];
    endcase
  endtask

  task automatic drain();
    while (pending_idx.size() != 0 || in_valid_i || expected_pairs.size() != 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_dim();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hffff;
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  // operand dims mostly match output, else a fresh random dim that may be 1, mismatched or equal
  task automatic random_config();
    logic [63:0] o, a, b;
    for (int k = 0; k < 4; k++) begin
      o[k*16 +: 16] = rand_dim();
      a[k*16 +: 16] = ($urandom_range(0, 2) != 0) ? o[k*16 +: 16] : rand_dim();
      b[k*16 +: 16] = ($urandom_range(0, 2) != 0) ? o[k*16 +: 16] : rand_dim();
    end
    cfg_write(REG_OUTPUT_SHAPE, o);
    cfg_write(REG_A_SHAPE, a);
    cfg_write(REG_B_SHAPE, b);
    cfg_write(REG_OUTPUT_RANK, $urandom_range(0, 7));
    cfg_write(REG_A_RANK, $urandom_range(0, 7));
    cfg_write(REG_B_RANK, $urandom_range(0, 7));
    n_configs++;
  endtask

  task automatic push_indices(int n);
    longint unsigned t;
    t = total_size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) pending_idx.push_back($urandom);
      else if (t > 64'hffffffff) pending_idx.push_back($urandom);
      else pending_idx.push_back($urandom_range(0, 32'(t - 1)));
    end
  endtask

  initial begin
    shp_out = SHAPE_RESET; shp_a = SHAPE_RESET; shp_b = SHAPE_RESET;
    rk_out = RANK_RESET; rk_a = RANK_RESET; rk_b = RANK_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: reset state, then a 3x4x5x6 output with broadcasts
    pending_idx.push_back(32'd0);
    pending_idx.push_back(32'hffffffff);
    drain();
    cfg_write(REG_OUTPUT_SHAPE, 64'h0003_0004_0005_0006);
    cfg_write(REG_A_SHAPE, 64'h0000_0004_0001_0006);
    cfg_write(REG_B_SHAPE, 64'h0009_0003_0005_0007);
    cfg_write(REG_OUTPUT_RANK, 3'd4);
    cfg_write(REG_A_RANK, 3'd3);
    cfg_write(REG_B_RANK, 3'd7);
    for (int i = 0; i < 12; i++) pending_idx.push_back(i * 31);
    pending_idx.push_back(32'd359);
    pending_idx.push_back(32'd360);
    pending_idx.push_back(32'hffffffff);
    pending_idx.push_back(32'h80000000);
    drain();
    cfg_write(REG_OUTPUT_RANK, 3'd0);
    cfg_write(REG_A_RANK, 3'd0);
    pending_idx.push_back(32'h5555aaaa);
    pending_idx.push_back(32'haaaa5555);
    drain();
    cfg_write(REG_OUTPUT_SHAPE, 64'hffff_ffff_ffff_ffff);
    cfg_write(REG_A_SHAPE, 64'hffff_ffff_ffff_ffff);
    cfg_write(REG_B_SHAPE, 64'h0);
    cfg_write(REG_OUTPUT_RANK, 3'd4);
    cfg_write(REG_A_RANK, 3'd4);
    cfg_write(REG_B_RANK, 3'd4);
    pending_idx.push_back(32'hffffffff);
    pending_idx.push_back(32'h0001fffe);
    drain();
    for (int p = 0; p < 25; p++) begin
      random_config();
      push_indices(50);
      drain();
    end
    $display("checked %0d transactions over %0d random shape settings", n_checked, n_configs);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("== FAIL ==");
    $finish;
  end
endmodule

[files.f]
rtl/bidx_pkg.sv
rtl/bidx_divider.sv
rtl/bidx_stride.sv
rtl/bidx_mac.sv
rtl/broadcast_index_generator.sv
rtl/bidx_checker.sv
test/tb.sv
